### rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants for the double ended queue unit
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int WORD_W        = 32;
    localparam int OPCODE_W      = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } state_t;

endpackage

`default_nettype wire

### rtl/core/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded deque of 32-bit words held in a ring buffer memory
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  command  | s_valid s_ready s_opcode s_value        | in
//  result   | m_valid m_ready m_word m_status m_last  | out
//
//  push and every flagged command: result goes straight into the output register
//  pop: the word passes the registered read of the storage memory, then the output register
//  dump: one memory read per stored word
//  m_ready low holds the output register and stalls a dump in place
//  reset clears front index, occupancy and the output valid; storage is
//  not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire         [deq_pkg::OPCODE_W-1:0]  s_opcode,
    input  wire  signed [deq_pkg::WORD_W-1:0]    s_value,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [deq_pkg::WORD_W-1:0]    m_word,
    output logic        [deq_pkg::STATUS_W-1:0]  m_status,
    output logic                                 m_last
);

    import deq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= DEPTH_SUM) begin
            sum = sum - DEPTH_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic signed [WORD_W-1:0] mem [DEPTH];

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       front_reg, front_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic [IDX_W-1:0]       dump_cnt_reg, dump_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [WORD_W-1:0] m_word_reg, m_word_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;
    logic                   m_last_reg, m_last_next;
    logic signed [WORD_W-1:0] rd_data_reg;

    logic                   mem_we, mem_re;
    logic [IDX_W-1:0]       mem_waddr, mem_raddr;
    logic                   out_free, accept, is_empty, is_full, dump_last;
    logic [IDX_W-1:0]       occ_idx;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign is_empty  = (occ_reg == '0);
    assign is_full   = (occ_reg == FULL_CNT);
    assign occ_idx   = occ_reg[IDX_W-1:0];
    assign dump_last = (CNT_W'(dump_cnt_reg) + CNT_W'(1)) == occ_reg;

    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;
    assign m_status = m_status_reg;
    assign m_last   = m_last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_opcode) inside
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (!is_empty) state_next = S_POP;
                        end
                        OP_DUMP: begin
                            if (!is_empty) state_next = S_DUMP;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_POP: state_next = S_IDLE;
            S_DUMP: begin
                if (out_free && dump_last) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        front_next    = front_reg;
        occ_next      = occ_reg;
        dump_cnt_next = dump_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_word_next   = m_word_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = slot_of(front_reg, occ_idx);
        mem_raddr     = front_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_opcode) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            m_valid_next  = 1'b1;
                            m_word_next   = '0;
                            m_last_next   = 1'b1;
                            if (is_full) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                m_status_next = STAT_OK;
                                mem_we        = 1'b1;
                                occ_next      = occ_reg + CNT_W'(1);
                                if (s_opcode == OP_PUSH_FRONT) begin
                                    front_next = (front_reg == '0) ? LAST_IDX
                                                                   : front_reg - IDX_W'(1);
                                    mem_waddr  = front_next;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_DUMP: begin
                            if (is_empty) begin
                                m_valid_next  = 1'b1;
                                m_word_next   = '0;
                                m_status_next = STAT_EMPTY;
                                m_last_next   = 1'b1;
                            end else begin
                                mem_re = 1'b1;
                                if (s_opcode == OP_POP_FRONT) begin
                                    mem_raddr  = front_reg;
                                    front_next = (front_reg == LAST_IDX) ? '0
                                                                         : front_reg + IDX_W'(1);
                                    occ_next   = occ_reg - CNT_W'(1);
                                end else if (s_opcode == OP_POP_BACK) begin
                                    mem_raddr = slot_of(front_reg, occ_idx - IDX_W'(1));
                                    occ_next  = occ_reg - CNT_W'(1);
                                end else begin
                                    mem_raddr     = front_reg;
                                    dump_cnt_next = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                m_valid_next  = 1'b1;
                m_word_next   = rd_data_reg;
                m_status_next = STAT_OK;
                m_last_next   = 1'b1;
            end
            S_DUMP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_word_next   = rd_data_reg;
                    m_status_next = STAT_OK;
                    m_last_next   = dump_last;
                    if (!dump_last) begin
                        dump_cnt_next = dump_cnt_reg + IDX_W'(1);
                        mem_re        = 1'b1;
                        mem_raddr     = slot_of(front_reg, dump_cnt_next);
                    end
                end
            end
            default: ;
        endcase
    end

    // storage memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= s_value;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dump_cnt_reg <= dump_cnt_next;
        m_word_reg   <= m_word_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

endmodule

`default_nettype wire
